FILE: rtl/dmsc_pkg.sv
// Package for the delta-modulation sample channel.
// Holds item kinds, register indexes, the result beat type and the period table.
// Depends on nothing; used by every other file under rtl.
package dmsc_pkg;

   // Kinds of input beat.
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_FETCH = 2'd2
   } req_kind_type;

   // Register indexes for a register write beat.
   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_LEVEL  = 3'd1;
   localparam logic [2:0] REG_ADDR   = 3'd2;
   localparam logic [2:0] REG_LENGTH = 3'd3;
   localparam logic [2:0] REG_ENABLE = 3'd4;

   localparam logic [15:0] BASE_ADDR   = 16'hC000;
   localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
   localparam logic [6:0]  LEVEL_TOP_STEP = 7'd125;

   // One result beat.
   typedef struct packed {
      logic [12:0] sample_out;
      logic        fetch_req;
      logic [15:0] fetch_addr;
      logic        active;
   } result_type;

   // Period reload value (period minus one) for each rate code.
   function automatic logic [8:0] period_reload(input logic [3:0] rate);
      logic [8:0] p;
      case (rate)
         4'd0:    p = 9'd428;
         4'd1:    p = 9'd380;
         4'd2:    p = 9'd340;
         4'd3:    p = 9'd320;
         4'd4:    p = 9'd286;
         4'd5:    p = 9'd254;
         4'd6:    p = 9'd226;
         4'd7:    p = 9'd214;
         4'd8:    p = 9'd190;
         4'd9:    p = 9'd160;
         4'd10:   p = 9'd142;
         4'd11:   p = 9'd128;
         4'd12:   p = 9'd106;
         4'd13:   p = 9'd85;
         4'd14:   p = 9'd72;
         default: p = 9'd54;
      endcase
      return p - 9'd1;
   endfunction

endpackage

FILE: rtl/dmsc_core.sv
// Channel state and per-beat update of the delta-modulation sample channel.
// Each accepted beat updates the registered state and yields its result combinationally.
// Depends on dmsc_pkg.
module dmsc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           req_type,
   input  logic [2:0]           req_reg_index,
   input  logic [7:0]           req_write_data,
   input  logic [7:0]           req_fetch_data,
   output dmsc_pkg::result_type result
);

   logic [6:0]  level_ff,         level_in;
   logic [7:0]  bit_shifter_ff,   bit_shifter_in;
   logic [3:0]  bits_left_ff,     bits_left_in;
   logic [15:0] cur_address_ff,   cur_address_in;
   logic [11:0] bytes_left_ff,    bytes_left_in;
   logic [15:0] start_address_ff, start_address_in;
   logic [11:0] start_length_ff,  start_length_in;
   logic        loop_on_ff,       loop_on_in;
   logic [3:0]  rate_sel_ff,      rate_sel_in;
   logic [8:0]  period_timer_ff,  period_timer_in;
   logic        channel_on_ff,    channel_on_in;
   logic        fetch_wait_ff,    fetch_wait_in;

   logic        fetch_req;
   logic [15:0] fetch_addr;
   logic [11:0] bytes_dec;

   assign bytes_dec = bytes_left_ff - 12'd1;

   // Next state for the beat being accepted.
   always_comb begin
      level_in         = level_ff;
      bit_shifter_in   = bit_shifter_ff;
      bits_left_in     = bits_left_ff;
      cur_address_in   = cur_address_ff;
      bytes_left_in    = bytes_left_ff;
      start_address_in = start_address_ff;
      start_length_in  = start_length_ff;
      loop_on_in       = loop_on_ff;
      rate_sel_in      = rate_sel_ff;
      period_timer_in  = period_timer_ff;
      channel_on_in    = channel_on_ff;
      fetch_wait_in    = fetch_wait_ff;
      fetch_req        = 1'b0;
      fetch_addr       = 16'd0;

      unique case (dmsc_pkg::req_kind_type'(req_type))
         dmsc_pkg::KIND_WRITE: begin
            unique case (req_reg_index)
               dmsc_pkg::REG_MODE: begin
                  loop_on_in  = req_write_data[6];
                  rate_sel_in = req_write_data[3:0];
               end
               dmsc_pkg::REG_LEVEL: begin
                  level_in = req_write_data[6:0];
               end
               dmsc_pkg::REG_ADDR: begin
                  // Base plus 64 per step; the sum never carries past bit 15.
                  start_address_in = {dmsc_pkg::BASE_ADDR[15:14], req_write_data, 6'd0};
                  cur_address_in   = {dmsc_pkg::BASE_ADDR[15:14], req_write_data, 6'd0};
               end
               dmsc_pkg::REG_LENGTH: begin
                  start_length_in = {req_write_data, 4'b0001};
                  bytes_left_in   = {req_write_data, 4'b0001};
               end
               dmsc_pkg::REG_ENABLE: begin
                  if (req_write_data[4]) begin
                     channel_on_in = 1'b1;
                     if (bytes_left_ff == 12'd0) begin
                        cur_address_in = start_address_ff;
                        bytes_left_in  = start_length_ff;
                     end
                  end else begin
                     channel_on_in = 1'b0;
                     bytes_left_in = 12'd0;
                     fetch_wait_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         dmsc_pkg::KIND_TICK: begin
            if (channel_on_ff) begin
               if (period_timer_ff == 9'd0) begin
                  period_timer_in = dmsc_pkg::period_reload(rate_sel_ff);
                  if (bits_left_ff == 4'd0) begin
                     // Shifter empty: request the next byte if any remain and no fetch is pending.
                     if (bytes_left_ff != 12'd0 && !fetch_wait_ff) begin
                        fetch_req      = 1'b1;
                        fetch_addr     = cur_address_ff;
                        cur_address_in = cur_address_ff + 16'd1;
                        bytes_left_in  = bytes_dec;
                        if (bytes_dec == 12'd0 && loop_on_ff) begin
                           cur_address_in = start_address_ff;
                           bytes_left_in  = start_length_ff;
                        end
                        fetch_wait_in = 1'b1;
                     end
                  end else begin
                     // Play one bit: step the level by two, staying in range.
                     if (bit_shifter_ff[0]) begin
                        if (level_ff <= dmsc_pkg::LEVEL_TOP_STEP) begin
                           level_in = level_ff + 7'd2;
                        end
                     end else begin
                        if (level_ff >= 7'd2) begin
                           level_in = level_ff - 7'd2;
                        end
                     end
                     bit_shifter_in = {1'b0, bit_shifter_ff[7:1]};
                     bits_left_in   = bits_left_ff - 4'd1;
                  end
               end else begin
                  period_timer_in = period_timer_ff - 9'd1;
               end
            end
         end
         dmsc_pkg::KIND_FETCH: begin
            if (fetch_wait_ff) begin
               bit_shifter_in = req_fetch_data;
               bits_left_in   = dmsc_pkg::BITS_PER_BYTE;
               fetch_wait_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Result of the beat: level times 48 as two shifted adds.
   always_comb begin
      result.sample_out = {1'b0, level_in, 5'd0} + {2'b00, level_in, 4'd0};
      result.fetch_req  = fetch_req;
      result.fetch_addr = fetch_addr;
      result.active     = (bytes_left_in != 12'd0);
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff         <= 7'd0;
         bit_shifter_ff   <= 8'd0;
         bits_left_ff     <= 4'd0;
         cur_address_ff   <= dmsc_pkg::BASE_ADDR;
         bytes_left_ff    <= 12'd0;
         start_address_ff <= dmsc_pkg::BASE_ADDR;
         start_length_ff  <= 12'd1;
         loop_on_ff       <= 1'b0;
         rate_sel_ff      <= 4'd0;
         period_timer_ff  <= 9'd0;
         channel_on_ff    <= 1'b0;
         fetch_wait_ff    <= 1'b0;
      end else if (accept) begin
         level_ff         <= level_in;
         bit_shifter_ff   <= bit_shifter_in;
         bits_left_ff     <= bits_left_in;
         cur_address_ff   <= cur_address_in;
         bytes_left_ff    <= bytes_left_in;
         start_address_ff <= start_address_in;
         start_length_ff  <= start_length_in;
         loop_on_ff       <= loop_on_in;
         rate_sel_ff      <= rate_sel_in;
         period_timer_ff  <= period_timer_in;
         channel_on_ff    <= channel_on_in;
         fetch_wait_ff    <= fetch_wait_in;
      end
   end

`ifndef SYNTHESIS
   // The shifter never holds more than one byte of bits.
   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= dmsc_pkg::BITS_PER_BYTE)
      else $error("bits_left exceeds one byte");

   // A fetch request is only made with the shifter empty and no fetch pending.
   a_req_when_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && fetch_req) |-> (bits_left_ff == 4'd0 && !fetch_wait_ff))
      else $error("fetch requested while shifter busy or fetch pending");

   // An issued request leaves a fetch pending.
   a_req_sets_wait: assert property (@(posedge clock) disable iff (reset)
      (accept && fetch_req) |=> fetch_wait_ff)
      else $error("fetch request did not mark a pending fetch");
`endif

endmodule

FILE: rtl/dmsc_obuf.sv
// Result buffer: an output register backed by one skid register.
// Lets a new beat enter while a finished result waits on a stalled output.
// Depends on dmsc_pkg.
module dmsc_obuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  dmsc_pkg::result_type load_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dmsc_pkg::result_type rsp_data
);

   logic                 out_valid_ff,  out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   dmsc_pkg::result_type out_data_ff,   out_data_in;
   dmsc_pkg::result_type skid_data_ff,  skid_data_in;
   logic                 out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Refill the output register from the skid first, then from a new beat.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = load;
            out_data_in  = load_data;
         end
      end else if (load) begin
         skid_valid_in = 1'b1;
         skid_data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTHESIS
   // The skid only fills behind an occupied output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while output register is empty");

   // No beat is loaded while the skid is occupied.
   a_no_load_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !load)
      else $error("beat loaded into a full buffer");

   // A beat loaded behind a stalled output lands in the skid.
   a_load_to_skid: assert property (@(posedge clock) disable iff (reset)
      (load && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("beat lost behind a stalled output");
`endif

endmodule

FILE: rtl/delta_modulation_sample_channel.sv
// Top level of the delta-modulation sample channel.
// Instantiates dmsc_core (state and update) and dmsc_obuf (result buffer).
// Depends on dmsc_pkg, dmsc_core and dmsc_obuf.
//
//   Channel    Handshake             Payload
//   request    req_valid/req_stall   req_type, req_reg_index, req_write_data,
//                                    req_fetch_data
//   response   rsp_valid/rsp_stall   rsp_sample_out, rsp_fetch_req,
//                                    rsp_fetch_addr, rsp_active
//
// One request beat is taken per clock while req_stall is low; its state update completes at that edge.
// Its response beat is registered in the output register, or in the skid register if the output is stalled.
// Synchronous reset clears the channel state and empties the result buffer.
// A stalled response holds; one more request beat is taken into the skid
// register, after which req_stall is raised until that beat moves to the output register.
module delta_modulation_sample_channel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_reg_index,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_fetch_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_sample_out,
   output logic        rsp_fetch_req,
   output logic [15:0] rsp_fetch_addr,
   output logic        rsp_active
);

   logic                 accept;
   logic                 buf_full;
   dmsc_pkg::result_type result;
   dmsc_pkg::result_type rsp_data;

   // A request beat is taken whenever the buffer has room.
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   dmsc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_type       (req_type),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .req_fetch_data (req_fetch_data),
      .result         (result)
   );

   dmsc_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_sample_out = rsp_data.sample_out;
   assign rsp_fetch_req  = rsp_data.fetch_req;
   assign rsp_fetch_addr = rsp_data.fetch_addr;
   assign rsp_active     = rsp_data.active;

endmodule
